/* rtl/iorbpd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// I/O read burst pattern detector package
// Shared types, codes and helpers for the classifier, the sequential-pattern
// tracker and the read-burst tracker.
// ----------------------------------------------------------------------------
package iorbpd_pkg;

    localparam int unsigned NOW_W    = 32;
    localparam int unsigned KB_W     = 16;
    localparam int unsigned SECTOR_W = 48;
    localparam int unsigned SCORE_W  = 8;
    localparam int unsigned TALLY_W  = 16;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [SCORE_W-1:0] SCORE_STEP_UP   = 8'd8;
    localparam logic [SCORE_W-1:0] SCORE_STEP_DOWN = 8'd3;
    localparam logic [SCORE_W-1:0] SCORE_MAX       = 8'd255;
    localparam logic [SCORE_W-1:0] SCORE_SEQ_LEVEL = 8'd96;

    // Word kinds
    localparam logic MODE_ARRIVAL  = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_READ_SIZE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_READ_SIZE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TINY_WRITE_SIZE    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_GAP_LIMIT      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_WINDOW_TICKS = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_COUNT_LIMIT  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_LENGTH_TICKS = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_TICKS     = 8'd7;

    typedef enum logic [2:0] {
        CLS_CRITICAL_READ = 3'd0,
        CLS_SMALL_READ    = 3'd1,
        CLS_LARGE_READ    = 3'd2,
        CLS_NORMAL_WRITE  = 3'd3,
        CLS_TINY_WRITE    = 3'd4
    } req_class_t;

    typedef struct packed {
        logic [15:0] window_ticks;
        logic [5:0]  count_limit;
        logic [15:0] length_ticks;
        logic [15:0] cooldown_ticks;
    } burst_cfg_t;

    typedef struct packed {
        logic read_evt;
        logic check_evt;
    } burst_cmd_t;

    typedef struct packed {
        logic               seq;
        logic [SCORE_W-1:0] score;
    } pat_status_t;

    typedef struct packed {
        logic burst_on;
        logic cooling;
        logic began;
        logic ended;
    } burst_status_t;

    // Wrapping signed difference a - b greater than zero
    function automatic logic tick_after(input logic [NOW_W-1:0] a,
                                        input logic [NOW_W-1:0] b);
        logic [NOW_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[NOW_W-1];
    endfunction

    function automatic logic tick_after_eq(input logic [NOW_W-1:0] a,
                                           input logic [NOW_W-1:0] b);
        logic [NOW_W-1:0] d;
        d = a - b;
        return !d[NOW_W-1];
    endfunction

    function automatic req_class_t classify(input logic            mode,
                                            input logic            is_write,
                                            input logic [KB_W-1:0] size_kb,
                                            input logic [7:0]      small_read_size,
                                            input logic [6:0]      tiny_write_size);
        req_class_t cls;
        if (mode == MODE_DISPATCH) begin
            cls = CLS_CRITICAL_READ;
        end else if (is_write) begin
            cls = (size_kb <= {9'd0, tiny_write_size}) ? CLS_TINY_WRITE : CLS_NORMAL_WRITE;
        end else if (size_kb <= {9'd0, small_read_size[7:1]}) begin
            cls = CLS_CRITICAL_READ;
        end else if (size_kb <= {8'd0, small_read_size}) begin
            cls = CLS_SMALL_READ;
        end else begin
            cls = CLS_LARGE_READ;
        end
        return cls;
    endfunction

endpackage
`default_nettype wire

/* rtl/iorbpd_pattern.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sequential pattern tracker
// Keeps the last read sector and a saturating score that climbs on close
// large reads and decays otherwise.
// ----------------------------------------------------------------------------
module iorbpd_pattern
    import iorbpd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                upd_en,
    input  wire logic [KB_W-1:0]     size_kb,
    input  wire logic [SECTOR_W-1:0] start_sector,
    input  wire logic [10:0]         large_read_size,
    input  wire logic [10:0]         seq_gap_limit,
    output pat_status_t              pat_next
);

    logic [SECTOR_W-1:0] prev_sector_reg, prev_sector_next;
    logic                prev_large_reg, prev_large_next;
    logic [SCORE_W-1:0]  score_reg, score_next;
    logic                seq_reg, seq_next;

    logic                big_read;
    logic                near;
    logic                hit;
    logic [SECTOR_W-1:0] fwd_gap;
    logic [SECTOR_W-1:0] bwd_gap;
    logic [SCORE_W:0]    score_up;
    logic [SCORE_W-1:0]  score_up_sat;
    logic [SCORE_W-1:0]  score_dn;

    assign big_read = size_kb >= {5'd0, large_read_size};
    assign fwd_gap  = start_sector - prev_sector_reg;
    assign bwd_gap  = prev_sector_reg - start_sector;
    assign near     = (start_sector >= prev_sector_reg)
                    ? (fwd_gap <= {37'd0, seq_gap_limit})
                    : (bwd_gap <= {37'd0, seq_gap_limit});
    assign hit      = near && big_read && prev_large_reg;

    assign score_up     = {1'b0, score_reg} + {1'b0, SCORE_STEP_UP};
    assign score_up_sat = score_up[SCORE_W] ? SCORE_MAX : score_up[SCORE_W-1:0];
    assign score_dn     = (score_reg > SCORE_STEP_DOWN) ? (score_reg - SCORE_STEP_DOWN) : '0;

    always_comb begin
        prev_sector_next = prev_sector_reg;
        prev_large_next  = prev_large_reg;
        score_next       = score_reg;
        seq_next         = seq_reg;
        if (upd_en) begin
            prev_sector_next = start_sector;
            prev_large_next  = big_read;
            // a zero previous sector means nothing recorded yet: just record
            if (prev_sector_reg != '0) begin
                if (hit) begin
                    score_next = score_up_sat;
                    seq_next   = score_up_sat > SCORE_SEQ_LEVEL;
                end else begin
                    score_next = score_dn;
                    seq_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sector_reg <= '0;
            prev_large_reg  <= 1'b0;
            score_reg       <= '0;
            seq_reg         <= 1'b0;
        end else begin
            prev_sector_reg <= prev_sector_next;
            prev_large_reg  <= prev_large_next;
            score_reg       <= score_next;
            seq_reg         <= seq_next;
        end
    end

    assign pat_next = '{seq: seq_next, score: score_next};

endmodule
`default_nettype wire

/* rtl/iorbpd_burst.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Read burst tracker
// Windowed read tally that opens a burst with a deadline, and the cooldown
// that follows a burst closed by a dispatch check.
// ----------------------------------------------------------------------------
module iorbpd_burst
    import iorbpd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire burst_cmd_t       cmd,
    input  wire logic [NOW_W-1:0] now,
    input  wire burst_cfg_t       cfg,
    output burst_status_t         status_next
);

    logic               window_valid_reg, window_valid_next;
    logic [NOW_W-1:0]   window_begin_reg, window_begin_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic               burst_reg, burst_next;
    logic               cool_reg, cool_next;
    logic [NOW_W-1:0]   end_time_reg, end_time_next;
    logic [NOW_W-1:0]   exit_time_reg, exit_time_next;

    logic               cool_done;
    logic               cool_rd;
    logic               restart;
    logic [TALLY_W-1:0] tally_base;
    logic [TALLY_W-1:0] tally_rd;
    logic               start;
    logic               expire;

    assign cool_done = cool_reg &&
                       tick_after(now, exit_time_reg + {16'd0, cfg.cooldown_ticks});
    assign cool_rd   = cool_reg && !cool_done;
    assign restart   = !window_valid_reg ||
                       tick_after(now, window_begin_reg + {16'd0, cfg.window_ticks});
    assign tally_base = restart ? '0 : tally_reg;
    // saturate at all ones
    assign tally_rd  = (&tally_base) ? tally_base : tally_base + TALLY_W'(1);
    assign start     = !burst_reg && (tally_rd >= {10'd0, cfg.count_limit}) && !cool_rd;
    assign expire    = burst_reg && tick_after_eq(now, end_time_reg);

    always_comb begin
        window_valid_next  = window_valid_reg;
        window_begin_next  = window_begin_reg;
        tally_next         = tally_reg;
        burst_next         = burst_reg;
        cool_next          = cool_reg;
        end_time_next      = end_time_reg;
        exit_time_next     = exit_time_reg;
        status_next.began  = 1'b0;
        status_next.ended  = 1'b0;
        if (cmd.read_evt) begin
            cool_next         = cool_rd;
            window_valid_next = 1'b1;
            if (restart) begin
                window_begin_next = now;
            end
            tally_next = tally_rd;
            if (start) begin
                burst_next        = 1'b1;
                end_time_next     = now + {16'd0, cfg.length_ticks};
                status_next.began = 1'b1;
            end
        end else if (cmd.check_evt && expire) begin
            burst_next        = 1'b0;
            cool_next         = 1'b1;
            exit_time_next    = now;
            tally_next        = '0;
            status_next.ended = 1'b1;
        end
        status_next.burst_on = burst_next;
        status_next.cooling  = cool_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_valid_reg <= 1'b0;
            window_begin_reg <= '0;
            tally_reg        <= '0;
            burst_reg        <= 1'b0;
            cool_reg         <= 1'b0;
            end_time_reg     <= '0;
            exit_time_reg    <= '0;
        end else begin
            window_valid_reg <= window_valid_next;
            window_begin_reg <= window_begin_next;
            tally_reg        <= tally_next;
            burst_reg        <= burst_next;
            cool_reg         <= cool_next;
            end_time_reg     <= end_time_next;
            exit_time_reg    <= exit_time_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/io_read_burst_pattern_detector_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// I/O read burst pattern detector
// Classifies storage requests and tracks sequential large reads and bursts.
// ----------------------------------------------------------------------------
// Each word is captured in an input register, then classified and applied to
// the pattern and burst state when it moves on, and its result is loaded into
// the output register in that same step, so m_valid rises once the word has
// passed the input and output registers. One word is accepted every cycle while
// the result side takes them; the rate is set by the state update, which each
// word sees after its predecessor.
// A stalled result holds the output register while the input register still
// takes one more word. Registers are written through the cfg port (always
// ready) and should only change while no word is in flight.
module io_read_burst_pattern_detector_unit
    import iorbpd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire logic                  s_mode,
    input  wire logic [NOW_W-1:0]      s_now,
    input  wire logic                  s_is_write,
    input  wire logic [KB_W-1:0]       s_size_kb,
    input  wire logic [SECTOR_W-1:0]   s_start_sector,

    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      logic [2:0]            m_req_class,
    output      logic                  m_sequential,
    output      logic [SCORE_W-1:0]    m_pattern_score,
    output      logic                  m_burst_on,
    output      logic                  m_cooling,
    output      logic                  m_burst_began,
    output      logic                  m_burst_ended
);

    // Configuration registers
    logic [7:0]  small_read_size_reg;
    logic [10:0] large_read_size_reg;
    logic [6:0]  tiny_write_size_reg;
    logic [10:0] seq_gap_limit_reg;
    burst_cfg_t  burst_cfg_reg;

    // Input register
    logic                in_valid_reg;
    logic                mode_reg;
    logic [NOW_W-1:0]    now_reg;
    logic                is_write_reg;
    logic [KB_W-1:0]     size_kb_reg;
    logic [SECTOR_W-1:0] start_sector_reg;

    // Output register
    logic                out_valid_reg, out_valid_next;
    req_class_t          class_reg;
    pat_status_t         pat_reg;
    burst_status_t       burst_reg;

    logic          advance;
    logic          is_read;
    burst_cmd_t    cmd;
    pat_status_t   pat_next;
    burst_status_t burst_next;
    req_class_t    class_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            small_read_size_reg         <= 8'd16;
            large_read_size_reg         <= 11'd128;
            tiny_write_size_reg         <= 7'd4;
            seq_gap_limit_reg           <= 11'd128;
            burst_cfg_reg.window_ticks  <= 16'd80;
            burst_cfg_reg.count_limit   <= 6'd8;
            burst_cfg_reg.length_ticks  <= 16'd150;
            burst_cfg_reg.cooldown_ticks <= 16'd50;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SMALL_READ_SIZE:    small_read_size_reg <= cfg_data[7:0];
                CFG_LARGE_READ_SIZE:    large_read_size_reg <= cfg_data[10:0];
                CFG_TINY_WRITE_SIZE:    tiny_write_size_reg <= cfg_data[6:0];
                CFG_SEQ_GAP_LIMIT:      seq_gap_limit_reg   <= cfg_data[10:0];
                CFG_BURST_WINDOW_TICKS: burst_cfg_reg.window_ticks <= cfg_data;
                CFG_BURST_COUNT_LIMIT:  burst_cfg_reg.count_limit  <= cfg_data[5:0];
                CFG_BURST_LENGTH_TICKS: burst_cfg_reg.length_ticks <= cfg_data;
                CFG_COOLDOWN_TICKS:     burst_cfg_reg.cooldown_ticks <= cfg_data;
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // Move a word on when the output register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg         <= s_mode;
            now_reg          <= s_now;
            is_write_reg     <= s_is_write;
            size_kb_reg      <= s_size_kb;
            start_sector_reg <= s_start_sector;
        end
    end

    assign is_read    = (mode_reg == MODE_ARRIVAL) && !is_write_reg;
    assign cmd        = '{read_evt:  advance && is_read,
                          check_evt: advance && (mode_reg == MODE_DISPATCH)};
    assign class_next = classify(mode_reg, is_write_reg, size_kb_reg,
                                 small_read_size_reg, tiny_write_size_reg);

    iorbpd_pattern u_pattern (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .upd_en          (cmd.read_evt),
        .size_kb         (size_kb_reg),
        .start_sector    (start_sector_reg),
        .large_read_size (large_read_size_reg),
        .seq_gap_limit   (seq_gap_limit_reg),
        .pat_next        (pat_next)
    );

    iorbpd_burst u_burst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .now         (now_reg),
        .cfg         (burst_cfg_reg),
        .status_next (burst_next)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            class_reg <= class_next;
            pat_reg   <= pat_next;
            burst_reg <= burst_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_req_class     = class_reg;
    assign m_sequential    = pat_reg.seq;
    assign m_pattern_score = pat_reg.score;
    assign m_burst_on      = burst_reg.burst_on;
    assign m_cooling       = burst_reg.cooling;
    assign m_burst_began   = burst_reg.began;
    assign m_burst_ended   = burst_reg.ended;

endmodule
`default_nettype wire

/* rtl/iorbpd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// I/O read burst pattern detector checker
// Port-level properties of the result words, bound to the top level.
// ----------------------------------------------------------------------------
module iorbpd_checker
    import iorbpd_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [2:0]         m_req_class,
    input wire logic               m_sequential,
    input wire logic [SCORE_W-1:0] m_pattern_score,
    input wire logic               m_burst_on,
    input wire logic               m_cooling,
    input wire logic               m_burst_began,
    input wire logic               m_burst_ended
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_req_class)
            && $stable(m_pattern_score) && $stable(m_burst_on) && $stable(m_cooling))
        else $error("result word changed while stalled");

    a_began_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_burst_began |-> m_burst_on && !m_cooling && !m_burst_ended)
        else $error("burst start without active burst");

    a_ended_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_burst_ended |-> !m_burst_on && m_cooling
            && (m_req_class == CLS_CRITICAL_READ))
        else $error("burst end without cooldown");

    a_seq_score: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sequential |-> m_pattern_score > SCORE_SEQ_LEVEL)
        else $error("sequential flag with low score");

    a_write_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_req_class == CLS_NORMAL_WRITE || m_req_class == CLS_TINY_WRITE)
            |-> !m_burst_began && !m_burst_ended)
        else $error("write word changed burst state");

endmodule

bind io_read_burst_pattern_detector_unit iorbpd_checker u_iorbpd_checker (.*);
`default_nettype wire
